// File: rtl/core/fses_pkg.sv
// shared types, constants and helpers for the fixed string entry sorter
package fses_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int WORD_W          = 64;
  localparam int ENTRY_WORDS     = 4;
  localparam int ENTRY_W         = WORD_W * ENTRY_WORDS;
  localparam int ENTRY_BYTES     = ENTRY_W / 8;
  localparam int RANK_W          = 5;

  // word 0 in the top bits, so one unsigned compare gives string order
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic [WORD_W-1:0] text_word0;
    logic [WORD_W-1:0] text_word1;
    logic [WORD_W-1:0] text_word2;
    logic [WORD_W-1:0] text_word3;
    logic              final_entry;
  } entry_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] sorted_word0;
    logic [WORD_W-1:0] sorted_word1;
    logic [WORD_W-1:0] sorted_word2;
    logic [WORD_W-1:0] sorted_word3;
    logic [RANK_W-1:0] rank;
    logic              last_of_run;
    logic              overflowed;
  } result_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // zero every byte after the first zero byte
  function automatic entry_t cut_terminator(entry_t e);
    entry_t r;
    logic   ended;
    r     = e;
    ended = 1'b0;
    for (int b = 0; b < ENTRY_BYTES; b++) begin
      if (ended) begin
        r[ENTRY_W-1-8*b -: 8] = 8'h00;
      end
      if (e[ENTRY_W-1-8*b -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/fses_cell.sv
// one sorter cell: holds one entry, shifts up on insert, down on drain
module fses_cell (
  input  logic               clk,
  input  fses_pkg::cell_ctl_t ctl,
  input  fses_pkg::entry_t   new_entry,
  input  logic               occ_self,
  input  logic               occ_left,
  input  logic               shift_left,
  input  fses_pkg::entry_t   left_data,
  input  fses_pkg::entry_t   right_data,
  output fses_pkg::entry_t   data,
  output logic               shift
);
  import fses_pkg::*;

  logic load;

  // strict less keeps equal entries in arrival order
  assign shift = occ_self && (new_entry < data);
  assign load  = ctl.insert && (shift || (!occ_self && occ_left));

  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      data <= right_data;
    end else if (load) begin
      data <= shift_left ? left_data : new_entry;
    end
  end

endmodule

// File: rtl/core/fixed_string_entry_sorter_unit.sv
// fixed string entry sorter top level: cell chain, load/drain control, result register
//
// Entries of 32 zero-padded bytes are loaded one per cycle into a chain of
// MAX_ENTRIES cells, each arriving entry dropping into its sorted place in the
// same cycle. The transfer that carries final_entry closes the set; the chain
// then shifts toward cell 0 one place per cycle and emits one result per cycle
// while result_ready allows, and entry_ready stays low while the set is emitted.
// Bytes after the first zero byte are treated as zero. Entries arriving while
// all cells are full are dropped and every result of that set has overflowed
// set.
module fixed_string_entry_sorter_unit #(
  parameter int MAX_ENTRIES = fses_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                entry_valid,
  output logic                entry_ready,
  input  fses_pkg::entry_in_t entry,
  output logic                result_valid,
  input  logic                result_ready,
  output fses_pkg::result_t   result
);
  import fses_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] rank_cnt;
  logic [CNT_W-1:0] rank_cnt_next;
  logic             overflow_seen;
  logic             overflow_seen_next;

  cell_ctl_t ctl;
  logic      take;
  logic      room;
  logic      step;
  entry_t    new_entry;

  entry_t                 cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_shift;
  logic [MAX_ENTRIES-1:0] occ;

  assign new_entry = cut_terminator({entry.text_word0, entry.text_word1,
                                     entry.text_word2, entry.text_word3});
  assign room      = count < CNT_W'(MAX_ENTRIES);

  // cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic   occ_left;
    logic   shift_left;
    entry_t left_data;
    entry_t right_data;

    assign occ[i] = count > CNT_W'(i);

    if (i == 0) begin : g_first
      assign occ_left   = 1'b1;
      assign shift_left = 1'b0;
      assign left_data  = new_entry;
    end else begin : g_inner
      assign occ_left   = occ[i-1];
      assign shift_left = cell_shift[i-1];
      assign left_data  = cell_data[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    fses_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .occ_self   (occ[i]),
      .occ_left   (occ_left),
      .shift_left (shift_left),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .shift      (cell_shift[i])
    );
  end

  // control outputs
  always_comb begin
    entry_ready = (state == ST_LOAD);
    take        = entry_valid && entry_ready;
    step        = (state == ST_DRAIN) && (!result_valid || result_ready);
    ctl.insert  = take && room;
    ctl.drain   = step;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (take && entry.final_entry) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (step && count == CNT_W'(1)) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    count_next         = count;
    rank_cnt_next      = rank_cnt;
    overflow_seen_next = overflow_seen;
    if (ctl.insert) begin
      count_next = count + CNT_W'(1);
    end
    if (take && !room) begin
      overflow_seen_next = 1'b1;
    end
    if (take && entry.final_entry) begin
      rank_cnt_next = '0;
    end
    if (step) begin
      count_next    = count - CNT_W'(1);
      rank_cnt_next = rank_cnt + CNT_W'(1);
      if (count == CNT_W'(1)) begin
        overflow_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      rank_cnt      <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      rank_cnt      <= rank_cnt_next;
      overflow_seen <= overflow_seen_next;
      if (step) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      result.sorted_word0 <= cell_data[0][ENTRY_W-1 -: WORD_W];
      result.sorted_word1 <= cell_data[0][ENTRY_W-WORD_W-1 -: WORD_W];
      result.sorted_word2 <= cell_data[0][ENTRY_W-2*WORD_W-1 -: WORD_W];
      result.sorted_word3 <= cell_data[0][WORD_W-1:0];
      result.rank         <= RANK_W'(rank_cnt);
      result.last_of_run  <= (count == CNT_W'(1));
      result.overflowed   <= overflow_seen;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_final_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (take && entry.final_entry) |=> (state == ST_DRAIN && count != '0))
    else $error("closing transfer did not start a nonempty drain");

  a_last_ends_set: assert property (@(posedge clk) disable iff (rst)
    (step && count == CNT_W'(1)) |=> (state == ST_LOAD && count == '0 && !overflow_seen))
    else $error("set not cleared after its last result");

  a_no_insert_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> !ctl.insert)
    else $error("insert while draining");

endmodule

// File: tb/fixed_string_entry_sorter_unit_test.sv
// self-checking testbench for the fixed string entry sorter, with an in-file scoreboard class
`timescale 1ns / 100ps

module fixed_string_entry_sorter_unit_test;

  import fses_pkg::*;

  localparam int TEXT_BYTES     = ENTRY_W / 8;
  localparam int DIRECTED_ITEMS = 14;
  localparam int RANDOM_ITEMS   = 300;
  localparam int HOLD_CYCLES    = 400;

  class sort_scoreboard;
    entry_t  held[$];
    bit      dropped;
    result_t expected[$];
    int      errors;

    function new();
      dropped = 1'b0;
      errors  = 0;
    endfunction

    // bytes past the first zero byte read as zero
    function entry_t clean_text(entry_t raw);
      entry_t mask;
      mask = '1;
      for (int b = 0; b < TEXT_BYTES; b++) begin
        if (raw[ENTRY_W-1-8*b -: 8] == 8'h00) begin
          mask = ~({ENTRY_W{1'b1}} >> (8 * (b + 1)));
          break;
        end
      end
      return raw & mask;
    endfunction

    function void note_entry(entry_in_t item);
      entry_t  text;
      result_t r;
      int      pos;
      int      n;
      text = clean_text({item.text_word0, item.text_word1, item.text_word2, item.text_word3});
      if (held.size() < MAX_ENTRIES_DEF) begin
        pos = held.size();
        while (pos > 0 && text < held[pos-1]) pos--;
        held.insert(pos, text);
      end else begin
        dropped = 1'b1;
      end
      if (item.final_entry) begin
        n = held.size();
        for (int k = 0; k < n; k++) begin
          r.sorted_word0 = held[k][255:192];
          r.sorted_word1 = held[k][191:128];
          r.sorted_word2 = held[k][127:64];
          r.sorted_word3 = held[k][63:0];
          r.rank         = k[RANK_W-1:0];
          r.last_of_run  = (k == n - 1);
          r.overflowed   = dropped;
          expected.push_back(r);
        end
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] exp_val,
                                logic [WORD_W-1:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %h, got %h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(result_t r);
      result_t e;
      if (expected.size() == 0) begin
        $error("result transfer with nothing expected: %h", r);
        errors++;
        return;
      end
      e = expected.pop_front();
      compare_field("sorted_word0", e.sorted_word0, r.sorted_word0);
      compare_field("sorted_word1", e.sorted_word1, r.sorted_word1);
      compare_field("sorted_word2", e.sorted_word2, r.sorted_word2);
      compare_field("sorted_word3", e.sorted_word3, r.sorted_word3);
      compare_field("rank", WORD_W'(e.rank), WORD_W'(r.rank));
      compare_field("last_of_run", WORD_W'(e.last_of_run), WORD_W'(r.last_of_run));
      compare_field("overflowed", WORD_W'(e.overflowed), WORD_W'(r.overflowed));
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic      clk;
  logic      rst          = 1'b1;
  logic      entry_valid  = 1'b0;
  logic      entry_ready;
  entry_in_t entry        = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  result_t   result;

  sort_scoreboard sb;
  bit tx_gappy      = 1'b0;
  bit hold_results  = 1'b0;
  int items_sent    = 0;

  fixed_string_entry_sorter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .entry_valid  (entry_valid),
    .entry_ready  (entry_ready),
    .entry        (entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic entry_t text_of(string s);
    entry_t t;
    t = '0;
    for (int i = 0; i < s.len() && i < TEXT_BYTES; i++) t[ENTRY_W-1-8*i -: 8] = s[i];
    return t;
  endfunction

  function automatic entry_t random_text();
    entry_t t;
    int     style;
    int     len;
    t     = '0;
    style = $urandom_range(0, 9);
    if (style < 5) begin
      len = $urandom_range(0, 8);
      for (int b = 0; b < len; b++) t[ENTRY_W-1-8*b -: 8] = 8'(8'h61 + $urandom_range(0, 2));
      if (style == 4) begin
        for (int b = len + 1; b < TEXT_BYTES; b++) begin
          t[ENTRY_W-1-8*b -: 8] = 8'($urandom_range(0, 255));
        end
      end
    end else if (style < 8) begin
      for (int b = 0; b < TEXT_BYTES; b++) t[ENTRY_W-1-8*b -: 8] = 8'($urandom_range(0, 255));
    end else if (style == 8) begin
      t = '1;
      if ($urandom_range(0, 1)) t[7:0] = 8'($urandom_range(0, 255));
    end else begin
      for (int b = 0; b < TEXT_BYTES - 1; b++) t[ENTRY_W-1-8*b -: 8] = 8'h7a;
      t[7:0] = 8'($urandom_range(0, 255));
    end
    return t;
  endfunction

  task automatic send_entry(input entry_t text, input bit last_one);
    int        gap;
    entry_in_t item;
    gap = tx_gappy ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      entry_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.text_word0  = text[255:192];
    item.text_word1  = text[191:128];
    item.text_word2  = text[127:64];
    item.text_word3  = text[63:0];
    item.final_entry = last_one;
    entry       <= item;
    entry_valid <= 1'b1;
    do @(posedge clk); while (!entry_ready);
    sb.note_entry(item);
    items_sent++;
  endtask

  task automatic wait_all_results();
    entry_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side: random stalls, stretches without stalls, one long hold-off
  initial begin
    int stall;
    int run_left;
    bit rx_gappy;
    run_left = 0;
    rx_gappy = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (run_left == 0) begin
        rx_gappy = $urandom_range(0, 2) != 0;
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      if (hold_results) begin
        hold_results = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = rx_gappy ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  initial begin
    entry_t t;
    int     set_no;
    int     size;
    int     pick;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-entry sets at both extremes
    send_entry('0, 1'b1);
    send_entry('1, 1'b1);

    // short strings, duplicates, junk after the terminator
    tx_gappy = 1'b1;
    send_entry(text_of("b"), 1'b0);
    send_entry(text_of("a"), 1'b0);
    send_entry(text_of("ab"), 1'b0);
    t = text_of("a");
    t[191:0] = {3{64'hdead_beef_0123_4567}};
    send_entry(t, 1'b0);
    send_entry({8'h00, {(ENTRY_W-8){1'b1}}}, 1'b0);
    send_entry('1, 1'b0);
    send_entry('0, 1'b0);
    send_entry(text_of("a"), 1'b1);

    // full-length entries with and without a zero in the last byte, and a short one
    tx_gappy = 1'b0;
    t = {TEXT_BYTES{8'h7a}};
    t[7:0] = 8'h01;
    send_entry(t, 1'b0);
    t[7:0] = 8'h7b;
    send_entry(t, 1'b0);
    t[7:0] = 8'h00;
    send_entry(t, 1'b0);
    send_entry(text_of("zz"), 1'b1);

    set_no = 0;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      tx_gappy = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 19);
      if (pick < 13) size = $urandom_range(1, 8);
      else if (pick < 17) size = $urandom_range(9, 31);
      else if (pick < 19) size = $urandom_range(32, 34);
      else size = $urandom_range(35, 40);
      if (set_no == 2) begin
        // full set, then the result side stops while entries keep coming
        hold_results = 1'b1;
        tx_gappy     = 1'b0;
        size         = MAX_ENTRIES_DEF;
      end
      if (set_no == 6) wait_all_results();
      for (int i = 0; i < size; i++) send_entry(random_text(), i == size - 1);
      set_no++;
    end

    entry_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: fixed_string_entry_sorter_unit.f
rtl/core/fses_pkg.sv
rtl/core/fses_cell.sv
rtl/core/fixed_string_entry_sorter_unit.sv
tb/fixed_string_entry_sorter_unit_test.sv
